/* rtl/cfs_pkg.sv */
// shared types, widths and codes for the colour flash sequencer
// used by every module under rtl; depends on nothing else
package cfs_pkg;

    // sizes
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int CHAN_W          = 8;
    localparam int SCALE_W         = 8;
    localparam int ENTRY_W         = 3 * CHAN_W + SCALE_W;
    localparam int INDEX_W         = 8;
    localparam int MS_W            = 16;
    localparam int PROG_W          = MS_W + 1;
    localparam int COUNT_W         = 9;
    localparam int MODE_W          = 2;
    localparam int OP_W            = 2;
    localparam int NUM_W           = CHAN_W + MS_W;
    localparam int LANES           = 3;

    // register port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    // modes
    localparam logic [MODE_W-1:0] MODE_JUMP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FADE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STROBE = 2'd2;

    // operations of an input word
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE          = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FIXED_BRIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FADE_PERIOD   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STROBE_LENGTH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WHITE_LEVEL   = 3'd5;

    // reset values and fixed levels
    localparam logic [MS_W-1:0]    FADE_PERIOD_RST = 16'd1000;
    localparam logic [SCALE_W-1:0] WHITE_LEVEL_RST = 8'd255;
    localparam logic [SCALE_W-1:0] BLACK_BRIGHT    = 8'd255;
    localparam logic [CHAN_W-1:0]  CHAN_FULL       = 8'hFF;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SCALE_W-1:0] fixed_brightness;
        logic [MS_W-1:0]    fade_period_ms;
        logic [MS_W-1:0]    strobe_length;
        logic [COUNT_W-1:0] entry_count;
        logic [SCALE_W-1:0] white_level;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load_wr;
        logic restart;
        logic capture;
        logic rd_nxt;
        logic cur_latch;
        logic mul_load;
        logic div_start;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fade_blend;
        logic div_busy;
    } dp_status_t;

endpackage

/* rtl/cfs_divider.sv */
// three-lane restoring divider, one quotient bit per lane per cycle
// depends on cfs_pkg
module cfs_divider (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        start,
    input  logic [cfs_pkg::MS_W-1:0]                    divisor,
    input  logic [cfs_pkg::LANES-1:0][cfs_pkg::NUM_W-1:0] numer,
    output logic                                        busy,
    output logic [cfs_pkg::LANES-1:0][cfs_pkg::CHAN_W-1:0] quotient
);

    localparam int STEP_W = $clog2(cfs_pkg::NUM_W + 1);

    logic                                           busy_reg;
    logic [STEP_W-1:0]                              count_reg;
    logic [cfs_pkg::MS_W-1:0]                       div_reg;
    logic [cfs_pkg::LANES-1:0][cfs_pkg::MS_W-1:0]   rem_reg;
    logic [cfs_pkg::LANES-1:0][cfs_pkg::NUM_W-1:0]  quo_reg;
    logic [cfs_pkg::LANES-1:0][cfs_pkg::MS_W-1:0]   rem_next;
    logic [cfs_pkg::LANES-1:0][cfs_pkg::NUM_W-1:0]  quo_next;

    // one restoring step per lane
    always_comb begin
        logic [cfs_pkg::MS_W:0] shifted;
        for (int l = 0; l < cfs_pkg::LANES; l++) begin
            shifted = {rem_reg[l], quo_reg[l][cfs_pkg::NUM_W-1]};
            if (shifted >= {1'b0, div_reg}) begin
                rem_next[l] = cfs_pkg::MS_W'(shifted - {1'b0, div_reg});
                quo_next[l] = {quo_reg[l][cfs_pkg::NUM_W-2:0], 1'b1};
            end else begin
                rem_next[l] = cfs_pkg::MS_W'(shifted);
                quo_next[l] = {quo_reg[l][cfs_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= STEP_W'(cfs_pkg::NUM_W);
        end else if (busy_reg) begin
            count_reg <= count_reg - STEP_W'(1);
            if (count_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= numer;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;

    always_comb begin
        for (int l = 0; l < cfs_pkg::LANES; l++) begin
            quotient[l] = quo_reg[l][cfs_pkg::CHAN_W-1:0];
        end
    end

endmodule

/* rtl/cfs_datapath.sv */
// colour table memory, sequence state, fade products, output register
// depends on cfs_pkg and cfs_divider
module cfs_datapath #(
    parameter int TABLE_DEPTH = cfs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfs_pkg::cfg_t                 cfg,
    input  cfs_pkg::ctrl_cmd_t            cmd,
    output cfs_pkg::dp_status_t           status,
    input  logic [cfs_pkg::INDEX_W-1:0]   s_entry_index,
    input  logic [cfs_pkg::CHAN_W-1:0]    s_load_red,
    input  logic [cfs_pkg::CHAN_W-1:0]    s_load_green,
    input  logic [cfs_pkg::CHAN_W-1:0]    s_load_blue,
    input  logic [cfs_pkg::SCALE_W-1:0]   s_load_scale,
    input  logic [cfs_pkg::MS_W-1:0]      s_elapsed_ms,
    output logic [cfs_pkg::CHAN_W-1:0]    m_red,
    output logic [cfs_pkg::CHAN_W-1:0]    m_green,
    output logic [cfs_pkg::CHAN_W-1:0]    m_blue,
    output logic [cfs_pkg::SCALE_W-1:0]   m_brightness,
    output logic                          m_auto_brightness
);

    localparam int POS_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = ($clog2(TABLE_DEPTH + 1) > cfs_pkg::COUNT_W) ?
                           $clog2(TABLE_DEPTH + 1) : cfs_pkg::COUNT_W;
    localparam int COL_W = 3 * cfs_pkg::CHAN_W;

    logic [cfs_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [cfs_pkg::ENTRY_W-1:0] mem_q_reg;
    logic [cfs_pkg::ENTRY_W-1:0] cur_reg;
    logic [POS_W-1:0]            rd_addr;
    logic [POS_W-1:0]            wr_addr;
    logic                        wr_ok;

    logic [POS_W-1:0]            position_reg, position_next;
    logic [cfs_pkg::MS_W-1:0]    phase_reg, phase_next;
    logic [cfs_pkg::PROG_W-1:0]  progress_reg, progress_next;
    logic [cfs_pkg::MS_W-1:0]    elapsed_reg;

    logic [CNT_W-1:0]            count_ext, depth_c, n, pos_ext, pos_inc;
    logic [POS_W-1:0]            pos_sel, nxt;
    logic                        n_zero;

    logic [cfs_pkg::MS_W-1:0]    period, d, p, d_minus_p;
    logic                        d_zero;
    logic [cfs_pkg::PROG_W-1:0]  progress_sum;
    logic [cfs_pkg::MS_W-1:0]    phase_inc;

    logic [cfs_pkg::LANES-1:0][cfs_pkg::NUM_W-1:0]  num_reg;
    logic [cfs_pkg::LANES-1:0][cfs_pkg::CHAN_W-1:0] quotient;
    logic                                            div_busy;

    logic [COL_W-1:0]            cur_color, blend_color, color_out;
    logic [cfs_pkg::SCALE_W-1:0] cur_scale, bright_out;
    logic                        auto_out;

    logic [cfs_pkg::CHAN_W-1:0]  red_reg, green_reg, blue_reg;
    logic [cfs_pkg::SCALE_W-1:0] bright_reg;
    logic                        auto_reg;

    // table position bookkeeping
    always_comb begin
        count_ext = CNT_W'(cfg.entry_count);
        depth_c   = CNT_W'(TABLE_DEPTH);
        n         = (count_ext > depth_c) ? depth_c : count_ext;
        n_zero    = (n == '0);
        pos_ext   = CNT_W'(position_reg);
        pos_sel   = (pos_ext < n) ? position_reg : '0;
        pos_inc   = CNT_W'(pos_sel) + CNT_W'(1);
        nxt       = (pos_inc >= n) ? '0 : POS_W'(pos_inc);
    end

    // fade timing terms
    always_comb begin
        period       = (cfg.fade_period_ms == '0) ? cfs_pkg::MS_W'(1) : cfg.fade_period_ms;
        d            = period - cfs_pkg::MS_W'(1);
        d_zero       = (d == '0);
        p            = (progress_reg > {1'b0, d}) ? d : progress_reg[cfs_pkg::MS_W-1:0];
        d_minus_p    = d - p;
        progress_sum = progress_reg + cfs_pkg::PROG_W'(elapsed_reg);
        phase_inc    = phase_reg + cfs_pkg::MS_W'(1);
    end

    assign status = '{fade_blend: (cfg.mode == cfs_pkg::MODE_FADE) && !n_zero && !d_zero,
                      div_busy:   div_busy};

    // table memory: one write port, one registered read port
    assign wr_ok   = (32'(s_entry_index) < 32'(TABLE_DEPTH));
    assign wr_addr = POS_W'(s_entry_index);
    assign rd_addr = cmd.rd_nxt ? nxt : pos_sel;

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && wr_ok) begin
            mem[wr_addr] <= {s_load_red, s_load_green, s_load_blue, s_load_scale};
        end
        mem_q_reg <= mem[rd_addr];
    end

    // captured tick fields and current entry
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            elapsed_reg <= s_elapsed_ms;
        end
        if (cmd.cur_latch) begin
            cur_reg <= mem_q_reg;
        end
    end

    // blend numerators, one pair of products per lane (lane 0 blue)
    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            for (int l = 0; l < cfs_pkg::LANES; l++) begin
                num_reg[l] <=
                    cfs_pkg::NUM_W'(cur_reg[cfs_pkg::SCALE_W + cfs_pkg::CHAN_W*l +: cfs_pkg::CHAN_W])
                        * cfs_pkg::NUM_W'(d_minus_p)
                  + cfs_pkg::NUM_W'(mem_q_reg[cfs_pkg::SCALE_W + cfs_pkg::CHAN_W*l +: cfs_pkg::CHAN_W])
                        * cfs_pkg::NUM_W'(p);
            end
        end
    end

    cfs_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .divisor  (d),
        .numer    (num_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign cur_color   = cur_reg[cfs_pkg::ENTRY_W-1:cfs_pkg::SCALE_W];
    assign cur_scale   = cur_reg[cfs_pkg::SCALE_W-1:0];
    assign blend_color = {quotient[2], quotient[1], quotient[0]};

    // result word and next sequence state by mode
    always_comb begin
        color_out     = '0;
        bright_out    = '0;
        auto_out      = 1'b0;
        position_next = position_reg;
        phase_next    = phase_reg;
        progress_next = progress_reg;
        case (cfg.mode)
            cfs_pkg::MODE_STROBE: begin
                if (phase_reg == '0) begin
                    if (n_zero) begin
                        color_out  = {cfs_pkg::CHAN_FULL, cfs_pkg::CHAN_FULL, cfs_pkg::CHAN_FULL};
                        bright_out = cfg.white_level;
                    end else begin
                        color_out     = cur_color;
                        bright_out    = (cfg.fixed_brightness != '0) ? cfg.fixed_brightness
                                                                     : cur_scale;
                        position_next = nxt;
                    end
                    auto_out = (bright_out == '0);
                end else begin
                    bright_out = cfs_pkg::BLACK_BRIGHT;
                end
                phase_next = (phase_inc >= cfg.strobe_length) ? '0 : phase_inc;
            end
            cfs_pkg::MODE_FADE: begin
                if (!n_zero) begin
                    color_out  = d_zero ? cur_color : blend_color;
                    bright_out = cfg.fixed_brightness;
                    auto_out   = (cfg.fixed_brightness == '0);
                    if (progress_sum >= cfs_pkg::PROG_W'(period)) begin
                        progress_next = '0;
                        position_next = nxt;
                    end else begin
                        progress_next = progress_sum;
                    end
                end
            end
            default: begin
                if (!n_zero) begin
                    color_out     = cur_color;
                    bright_out    = (cfg.fixed_brightness != '0) ? cfg.fixed_brightness
                                                                 : cur_scale;
                    position_next = nxt;
                end
            end
        endcase
    end

    // sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            phase_reg    <= '0;
            progress_reg <= '0;
        end else if (cmd.restart) begin
            position_reg <= '0;
            phase_reg    <= '0;
            progress_reg <= '0;
        end else if (cmd.commit) begin
            position_reg <= position_next;
            phase_reg    <= phase_next;
            progress_reg <= progress_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            red_reg    <= color_out[3*cfs_pkg::CHAN_W-1:2*cfs_pkg::CHAN_W];
            green_reg  <= color_out[2*cfs_pkg::CHAN_W-1:cfs_pkg::CHAN_W];
            blue_reg   <= color_out[cfs_pkg::CHAN_W-1:0];
            bright_reg <= auto_out ? '0 : bright_out;
            auto_reg   <= auto_out;
        end
    end

    assign m_red             = red_reg;
    assign m_green           = green_reg;
    assign m_blue            = blue_reg;
    assign m_brightness      = bright_reg;
    assign m_auto_brightness = auto_reg;

endmodule

/* rtl/cfs_ctrl.sv */
// controller state machine: input handshake, step sequencing, output valid
// depends on cfs_pkg
module cfs_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [cfs_pkg::OP_W-1:0]     s_op,
    output logic                         m_valid,
    input  logic                         m_ready,
    input  cfs_pkg::dp_status_t          status,
    output cfs_pkg::ctrl_cmd_t           cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_RD_CUR   = 7'b0000010,
        ST_RD_NXT   = 7'b0000100,
        ST_MUL      = 7'b0001000,
        ST_DIV_GO   = 7'b0010000,
        ST_DIV_WAIT = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = (state_reg == ST_IDLE) && s_valid;
    assign out_free = !out_valid_reg || m_ready;

    // command decode
    always_comb begin
        cmd           = '0;
        cmd.load_wr   = accept && (s_op == cfs_pkg::OP_LOAD);
        cmd.restart   = accept && (s_op == cfs_pkg::OP_RESTART);
        cmd.capture   = accept && (s_op == cfs_pkg::OP_TICK);
        cmd.rd_nxt    = (state_reg == ST_RD_NXT);
        cmd.cur_latch = (state_reg == ST_RD_NXT);
        cmd.mul_load  = (state_reg == ST_MUL);
        cmd.div_start = (state_reg == ST_DIV_GO);
        cmd.commit    = (state_reg == ST_DONE) && out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op == cfs_pkg::OP_TICK)) begin
                    state_next = ST_RD_CUR;
                end
            end
            ST_RD_CUR:   state_next = ST_RD_NXT;
            ST_RD_NXT:   state_next = status.fade_blend ? ST_MUL : ST_DONE;
            ST_MUL:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // output word valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

/* rtl/cfs_regs.sv */
// configuration registers behind the register port
// depends on cfs_pkg
module cfs_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfs_pkg::ADDR_W-1:0]    paddr,
    input  logic [cfs_pkg::DATA_W-1:0]    pwdata,
    output logic [cfs_pkg::DATA_W-1:0]    prdata,
    output cfs_pkg::cfg_t                 cfg
);

    cfs_pkg::cfg_t                  cfg_reg;
    logic [cfs_pkg::REG_IDX_W-1:0]  idx;
    logic                           wr_en;

    assign idx   = paddr[cfs_pkg::ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode             <= cfs_pkg::MODE_JUMP;
            cfg_reg.fixed_brightness <= '0;
            cfg_reg.fade_period_ms   <= cfs_pkg::FADE_PERIOD_RST;
            cfg_reg.strobe_length    <= '0;
            cfg_reg.entry_count      <= '0;
            cfg_reg.white_level      <= cfs_pkg::WHITE_LEVEL_RST;
        end else if (wr_en) begin
            unique case (idx)
                cfs_pkg::REG_MODE:
                    cfg_reg.mode <= pwdata[cfs_pkg::MODE_W-1:0];
                cfs_pkg::REG_FIXED_BRIGHT:
                    cfg_reg.fixed_brightness <= pwdata[cfs_pkg::SCALE_W-1:0];
                cfs_pkg::REG_FADE_PERIOD:
                    cfg_reg.fade_period_ms <= pwdata[cfs_pkg::MS_W-1:0];
                cfs_pkg::REG_STROBE_LENGTH:
                    cfg_reg.strobe_length <= pwdata[cfs_pkg::MS_W-1:0];
                cfs_pkg::REG_ENTRY_COUNT:
                    cfg_reg.entry_count <= pwdata[cfs_pkg::COUNT_W-1:0];
                cfs_pkg::REG_WHITE_LEVEL:
                    cfg_reg.white_level <= pwdata[cfs_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        unique case (idx)
            cfs_pkg::REG_MODE:          prdata = cfs_pkg::DATA_W'(cfg_reg.mode);
            cfs_pkg::REG_FIXED_BRIGHT:  prdata = cfs_pkg::DATA_W'(cfg_reg.fixed_brightness);
            cfs_pkg::REG_FADE_PERIOD:   prdata = cfs_pkg::DATA_W'(cfg_reg.fade_period_ms);
            cfs_pkg::REG_STROBE_LENGTH: prdata = cfs_pkg::DATA_W'(cfg_reg.strobe_length);
            cfs_pkg::REG_ENTRY_COUNT:   prdata = cfs_pkg::DATA_W'(cfg_reg.entry_count);
            cfs_pkg::REG_WHITE_LEVEL:   prdata = cfs_pkg::DATA_W'(cfg_reg.white_level);
            default:                    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/color_flash_sequencer.sv */
// top level of the colour flash sequencer
// depends on cfs_pkg, cfs_regs, cfs_ctrl, cfs_datapath and cfs_divider
//
// Input words carry an op: load writes one table entry (colour and scale),
// restart clears position, strobe phase and fade progress, tick produces one
// output word (colour, brightness, automatic brightness flag). Load and
// restart are taken and s_ready stays high. A tick holds s_ready
// low while it works: jump, strobe and fades that need no blend pass through
// RD_CUR, RD_NXT and DONE from acceptance to the output register; a blended
// fade also passes MUL, DIV_GO and DIV_WAIT, waiting on the 24-step restoring
// divider that runs the three colour lanes side by side. Table reads go through
// a single registered memory port, so the current and next entries are read
// in turn. The next tick can be taken in the cycle after the result is
// registered, so ticks do not overlap.
// The output register holds one finished word; the next tick may be accepted
// while it waits, and stalls only at its own result until m_ready frees it.
// Reset (aresetn, synchronous, active low) restores register defaults and
// clears sequence state; table contents are undefined until loaded.
// Registers sit at byte addresses 4*i on the APB-style port; pready is tied high.
module color_flash_sequencer #(
    parameter int TABLE_DEPTH = cfs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfs_pkg::ADDR_W-1:0]    paddr,
    input  logic [cfs_pkg::DATA_W-1:0]    pwdata,
    output logic [cfs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cfs_pkg::OP_W-1:0]      s_op,
    input  logic [cfs_pkg::INDEX_W-1:0]   s_entry_index,
    input  logic [cfs_pkg::CHAN_W-1:0]    s_load_red,
    input  logic [cfs_pkg::CHAN_W-1:0]    s_load_green,
    input  logic [cfs_pkg::CHAN_W-1:0]    s_load_blue,
    input  logic [cfs_pkg::SCALE_W-1:0]   s_load_scale,
    input  logic [cfs_pkg::MS_W-1:0]      s_elapsed_ms,
    // output words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cfs_pkg::CHAN_W-1:0]    m_red,
    output logic [cfs_pkg::CHAN_W-1:0]    m_green,
    output logic [cfs_pkg::CHAN_W-1:0]    m_blue,
    output logic [cfs_pkg::SCALE_W-1:0]   m_brightness,
    output logic                          m_auto_brightness
);

    cfs_pkg::cfg_t        cfg;
    cfs_pkg::ctrl_cmd_t   cmd;
    cfs_pkg::dp_status_t  status;

    assign pready = 1'b1;

    // configuration registers
    cfs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // sequencing
    cfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // table, state and arithmetic
    cfs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .cmd               (cmd),
        .status            (status),
        .s_entry_index     (s_entry_index),
        .s_load_red        (s_load_red),
        .s_load_green      (s_load_green),
        .s_load_blue       (s_load_blue),
        .s_load_scale      (s_load_scale),
        .s_elapsed_ms      (s_elapsed_ms),
        .m_red             (m_red),
        .m_green           (m_green),
        .m_blue            (m_blue),
        .m_brightness      (m_brightness),
        .m_auto_brightness (m_auto_brightness)
    );

    // no new word while the divider runs
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_busy |-> !s_ready)
        else $error("input taken while divider busy");

    // load and restart never block the input
    a_short_op_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_op != cfs_pkg::OP_TICK)) |=> s_ready)
        else $error("ready dropped after load or restart");

    // a tick occupies the block
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_op == cfs_pkg::OP_TICK)) |=> !s_ready)
        else $error("ready held after tick accepted");

    // a committed result shows up on the output
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("committed word not presented");

endmodule

/* test/tb_top.sv */
// self-checking bench for the colour flash sequencer: directed words, then random phases
// depends on cfs_pkg and rtl/color_flash_sequencer.sv; predicts every frame on its own
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH         = cfs_pkg::TABLE_DEPTH_DEF;
    localparam int          PHASES        = 16;
    localparam int          PHASE_WORDS   = 20;
    localparam int          FILL_PHASE    = 6;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int          LIMIT_NS      = 2_000_000;
    localparam logic [cfs_pkg::OP_W-1:0]   OP_UNUSED   = 2'd3;
    localparam logic [cfs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [cfs_pkg::OP_W-1:0]    op;
        logic [cfs_pkg::INDEX_W-1:0] index;
        logic [cfs_pkg::CHAN_W-1:0]  red;
        logic [cfs_pkg::CHAN_W-1:0]  green;
        logic [cfs_pkg::CHAN_W-1:0]  blue;
        logic [cfs_pkg::SCALE_W-1:0] scale;
        logic [cfs_pkg::MS_W-1:0]    elapsed;
    } word_t;

    typedef struct packed {
        logic [cfs_pkg::CHAN_W-1:0]  red;
        logic [cfs_pkg::CHAN_W-1:0]  green;
        logic [cfs_pkg::CHAN_W-1:0]  blue;
        logic [cfs_pkg::SCALE_W-1:0] brightness;
        logic                        auto_b;
    } frame_t;

    // shadow of the sequencer: table, position, strobe phase, fade progress
    class frame_tracker;
        cfs_pkg::cfg_t               cfg;
        logic [23:0]                 colors [DEPTH];
        logic [cfs_pkg::SCALE_W-1:0] scales [DEPTH];
        bit                          loaded [DEPTH];
        logic [cfs_pkg::INDEX_W-1:0] position;
        logic [cfs_pkg::MS_W-1:0]    phase;
        logic [cfs_pkg::PROG_W-1:0]  progress;
        frame_t                      expected_frames [$];
        int unsigned                 mismatches;

        function new();
            cfg = '{mode: cfs_pkg::MODE_JUMP, fixed_brightness: '0,
                    fade_period_ms: cfs_pkg::FADE_PERIOD_RST,
                    strobe_length: '0, entry_count: '0,
                    white_level: cfs_pkg::WHITE_LEVEL_RST};
            position   = '0;
            phase      = '0;
            progress   = '0;
            mismatches = 0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        function void set_reg(logic [cfs_pkg::REG_IDX_W-1:0] idx,
                              logic [cfs_pkg::DATA_W-1:0] val);
            case (idx)
                cfs_pkg::REG_MODE:          cfg.mode = val[cfs_pkg::MODE_W-1:0];
                cfs_pkg::REG_FIXED_BRIGHT:  cfg.fixed_brightness = val[cfs_pkg::SCALE_W-1:0];
                cfs_pkg::REG_FADE_PERIOD:   cfg.fade_period_ms = val[cfs_pkg::MS_W-1:0];
                cfs_pkg::REG_STROBE_LENGTH: cfg.strobe_length = val[cfs_pkg::MS_W-1:0];
                cfs_pkg::REG_ENTRY_COUNT:   cfg.entry_count = val[cfs_pkg::COUNT_W-1:0];
                cfs_pkg::REG_WHITE_LEVEL:   cfg.white_level = val[cfs_pkg::SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned loaded_prefix();
            for (int i = 0; i < DEPTH; i++)
                if (!loaded[i]) return i;
            return DEPTH;
        endfunction

        function int unsigned waiting();
            return expected_frames.size();
        endfunction

        // one tick: work out the frame and move the sequence on
        function frame_t predict_frame(logic [cfs_pkg::MS_W-1:0] elapsed);
            frame_t                      f;
            int unsigned                 n, pos, nxt, period, d, p, num;
            logic [23:0]                 cur, nx, col;
            logic [cfs_pkg::SCALE_W-1:0] bright;
            bit                          autob;
            col    = '0;
            bright = '0;
            autob  = 1'b0;
            n   = (cfg.entry_count > DEPTH) ? DEPTH : cfg.entry_count;
            pos = (position < n) ? position : 0;
            nxt = (pos + 1 >= n) ? 0 : pos + 1;
            if (cfg.mode == cfs_pkg::MODE_STROBE) begin
                // colour on the first tick of a cycle, black on the rest
                if (phase == 0) begin
                    if (n == 0) begin
                        col    = 24'hFFFFFF;
                        bright = cfg.white_level;
                    end else begin
                        col      = colors[pos];
                        bright   = (cfg.fixed_brightness != 0) ? cfg.fixed_brightness
                                                               : scales[pos];
                        position = cfs_pkg::INDEX_W'(nxt);
                    end
                    autob = (bright == 0);
                end else begin
                    bright = cfs_pkg::BLACK_BRIGHT;
                end
                phase = cfs_pkg::MS_W'(phase + 1);
                if (phase >= cfg.strobe_length) phase = '0;
            end else if (cfg.mode == cfs_pkg::MODE_FADE) begin
                if (n != 0) begin
                    period = (cfg.fade_period_ms == 0) ? 1 : cfg.fade_period_ms;
                    d      = period - 1;
                    cur    = colors[pos];
                    nx     = colors[nxt];
                    if (d == 0) begin
                        col = cur;
                    end else begin
                        // weighted average per lane, floor rounding
                        p = (progress > d) ? d : progress;
                        for (int k = 0; k < 24; k += 8) begin
                            num          = cur[k +: 8] * (d - p) + nx[k +: 8] * p;
                            col[k +: 8]  = 8'(num / d);
                        end
                    end
                    if (cfg.fixed_brightness != 0) bright = cfg.fixed_brightness;
                    else autob = 1'b1;
                    progress = progress + elapsed;
                    if (progress >= period) begin
                        progress = '0;
                        position = cfs_pkg::INDEX_W'(nxt);
                    end
                end
            end else begin
                // jump, and the unused mode behaves the same
                if (n != 0) begin
                    col      = colors[pos];
                    bright   = (cfg.fixed_brightness != 0) ? cfg.fixed_brightness : scales[pos];
                    position = cfs_pkg::INDEX_W'(nxt);
                end
            end
            f.red        = col[23:16];
            f.green      = col[15:8];
            f.blue       = col[7:0];
            f.brightness = autob ? '0 : bright;
            f.auto_b     = autob;
            return f;
        endfunction

        // accepted input word
        function void take_word(word_t w);
            case (w.op)
                cfs_pkg::OP_LOAD: begin
                    colors[w.index] = {w.red, w.green, w.blue};
                    scales[w.index] = w.scale;
                    loaded[w.index] = 1'b1;
                end
                cfs_pkg::OP_RESTART: begin
                    position = '0;
                    phase    = '0;
                    progress = '0;
                end
                cfs_pkg::OP_TICK: expected_frames.push_back(predict_frame(w.elapsed));
                default: ;
            endcase
        endfunction

        task report(string what);
            if (mismatches < 100) $display("mismatch at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        task compare(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // accepted output word against the oldest expected frame
        task check_frame(frame_t got);
            frame_t want;
            if (expected_frames.size() == 0) begin
                report($sformatf("frame with nothing expected: %0h", got));
                return;
            end
            want = expected_frames.pop_front();
            compare("red", got.red, want.red);
            compare("green", got.green, want.green);
            compare("blue", got.blue, want.blue);
            compare("brightness", got.brightness, want.brightness);
            compare("auto_brightness", 8'(got.auto_b), 8'(want.auto_b));
        endtask
    endclass

    frame_tracker frames = new();

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [cfs_pkg::ADDR_W-1:0]    paddr   = '0;
    logic [cfs_pkg::DATA_W-1:0]    pwdata  = '0;
    logic [cfs_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [cfs_pkg::OP_W-1:0]      s_op          = '0;
    logic [cfs_pkg::INDEX_W-1:0]   s_entry_index = '0;
    logic [cfs_pkg::CHAN_W-1:0]    s_load_red    = '0;
    logic [cfs_pkg::CHAN_W-1:0]    s_load_green  = '0;
    logic [cfs_pkg::CHAN_W-1:0]    s_load_blue   = '0;
    logic [cfs_pkg::SCALE_W-1:0]   s_load_scale  = '0;
    logic [cfs_pkg::MS_W-1:0]      s_elapsed_ms  = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [cfs_pkg::CHAN_W-1:0]    m_red, m_green, m_blue;
    logic [cfs_pkg::SCALE_W-1:0]   m_brightness;
    logic                          m_auto_brightness;
    bit                            in_steady  = 1'b0;
    bit                            out_steady = 1'b0;

    color_flash_sequencer u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_entry_index     (s_entry_index),
        .s_load_red        (s_load_red),
        .s_load_green      (s_load_green),
        .s_load_blue       (s_load_blue),
        .s_load_scale      (s_load_scale),
        .s_elapsed_ms      (s_elapsed_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_red             (m_red),
        .m_green           (m_green),
        .m_blue            (m_blue),
        .m_brightness      (m_brightness),
        .m_auto_brightness (m_auto_brightness)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // output side: check each accepted word, stall at random
    always @(posedge aclk) begin : out_side
        frame_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen = '{red: m_red, green: m_green, blue: m_blue,
                     brightness: m_brightness, auto_b: m_auto_brightness};
            frames.check_frame(seen);
        end
        m_ready <= out_steady || ($urandom_range(99) >= 38);
    end

    function automatic word_t make_word(logic [cfs_pkg::OP_W-1:0] op, int unsigned idx,
                                        int unsigned r, int unsigned g, int unsigned b,
                                        int unsigned s, int unsigned ms);
        word_t w;
        w.op      = op;
        w.index   = cfs_pkg::INDEX_W'(idx);
        w.red     = cfs_pkg::CHAN_W'(r);
        w.green   = cfs_pkg::CHAN_W'(g);
        w.blue    = cfs_pkg::CHAN_W'(b);
        w.scale   = cfs_pkg::SCALE_W'(s);
        w.elapsed = cfs_pkg::MS_W'(ms);
        return w;
    endfunction

    // present one input word and hold it until taken
    task automatic send_word(word_t w);
        while (!in_steady && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= w.op;
        s_entry_index <= w.index;
        s_load_red    <= w.red;
        s_load_green  <= w.green;
        s_load_blue   <= w.blue;
        s_load_scale  <= w.scale;
        s_elapsed_ms  <= w.elapsed;
        do @(posedge aclk); while (!s_ready);
        frames.take_word(w);
    endtask

    task automatic tick(int unsigned ms);
        send_word(make_word(cfs_pkg::OP_TICK, 0, 0, 0, 0, 0, ms));
    endtask

    task automatic load(int unsigned idx, int unsigned r, int unsigned g, int unsigned b,
                        int unsigned s);
        send_word(make_word(cfs_pkg::OP_LOAD, idx, r, g, b, s, 0));
    endtask

    // setup phase and access phase, then the bus goes idle
    task automatic write_reg(logic [cfs_pkg::REG_IDX_W-1:0] idx,
                             logic [cfs_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frames.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // stop sending, wait for every frame, then let the block go quiet
    task automatic drain();
        s_valid <= 1'b0;
        while (frames.waiting() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // random upper bits that the registers should ignore
    function automatic logic [cfs_pkg::DATA_W-1:0] junk(int unsigned width);
        logic [cfs_pkg::DATA_W-1:0] v;
        v = $urandom_range(1) ? $urandom : '0;
        return v & ~((32'd1 << width) - 1);
    endfunction

    // one register setting per phase; the count never reaches an unloaded entry
    task automatic random_settings();
        int unsigned                 front, count, pick;
        logic [cfs_pkg::MODE_W-1:0]  mode;
        logic [cfs_pkg::MS_W-1:0]    period, slen;
        logic [cfs_pkg::SCALE_W-1:0] fixed, white;
        front = frames.loaded_prefix();
        case ($urandom_range(4))
            0:       count = 0;
            1:       count = front;
            2:       count = (front > 0) ? 1 : 0;
            default: count = $urandom_range(front, 0);
        endcase
        if (front == DEPTH && $urandom_range(1)) count = $urandom_range(511, DEPTH);
        pick = $urandom_range(9);
        mode = (pick < 3) ? cfs_pkg::MODE_JUMP : (pick < 6) ? cfs_pkg::MODE_FADE :
               (pick < 9) ? cfs_pkg::MODE_STROBE : MODE_UNUSED;
        case ($urandom_range(5))
            0:       period = 16'd0;
            1:       period = 16'd1;
            2:       period = 16'hFFFF;
            3:       period = cfs_pkg::MS_W'($urandom);
            default: period = cfs_pkg::MS_W'($urandom_range(40, 2));
        endcase
        case ($urandom_range(5))
            0:       slen = 16'd0;
            1:       slen = 16'd1;
            2:       slen = 16'hFFFF;
            3:       slen = cfs_pkg::MS_W'($urandom);
            default: slen = cfs_pkg::MS_W'($urandom_range(8, 2));
        endcase
        pick  = $urandom_range(9);
        fixed = (pick < 5) ? 8'd0 : (pick < 7) ? 8'hFF : 8'($urandom);
        pick  = $urandom_range(2);
        white = (pick == 0) ? 8'd0 : (pick == 1) ? 8'hFF : 8'($urandom);
        write_reg(cfs_pkg::REG_MODE, junk(cfs_pkg::MODE_W) | mode);
        write_reg(cfs_pkg::REG_FIXED_BRIGHT, junk(cfs_pkg::SCALE_W) | fixed);
        write_reg(cfs_pkg::REG_FADE_PERIOD, junk(cfs_pkg::MS_W) | period);
        write_reg(cfs_pkg::REG_STROBE_LENGTH, junk(cfs_pkg::MS_W) | slen);
        write_reg(cfs_pkg::REG_ENTRY_COUNT, junk(cfs_pkg::COUNT_W) | count);
        write_reg(cfs_pkg::REG_WHITE_LEVEL, junk(cfs_pkg::SCALE_W) | white);
    endtask

    // mostly ticks and loads, loads often at the first unloaded entry
    function automatic word_t random_word();
        word_t       w;
        int unsigned pick, front;
        front     = frames.loaded_prefix();
        w.index   = cfs_pkg::INDEX_W'($urandom);
        w.red     = cfs_pkg::CHAN_W'($urandom);
        w.green   = cfs_pkg::CHAN_W'($urandom);
        w.blue    = cfs_pkg::CHAN_W'($urandom);
        w.scale   = cfs_pkg::SCALE_W'($urandom);
        w.elapsed = cfs_pkg::MS_W'($urandom);
        if ($urandom_range(99) < 60)
            w.elapsed = cfs_pkg::MS_W'($urandom_range(frames.cfg.fade_period_ms, 0));
        pick = $urandom_range(99);
        if (pick < 55) begin
            w.op = cfs_pkg::OP_TICK;
        end else if (pick < 85) begin
            w.op = cfs_pkg::OP_LOAD;
            if (front < DEPTH && $urandom_range(1)) w.index = cfs_pkg::INDEX_W'(front);
        end else if (pick < 95) begin
            w.op = cfs_pkg::OP_RESTART;
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: black in jump, unused op, restart
        tick(16'hFFFF);
        send_word(make_word(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_word(make_word(cfs_pkg::OP_RESTART, 0, 0, 0, 0, 0, 0));
        // empty table strobes white, then white at zero scale asks for auto
        drain();
        write_reg(cfs_pkg::REG_MODE, cfs_pkg::DATA_W'(cfs_pkg::MODE_STROBE));
        tick(0);
        drain();
        write_reg(cfs_pkg::REG_WHITE_LEVEL, 0);
        tick(0);
        // entries at the extremes of colour and scale
        load(0, 8'hFF, 8'h00, 8'hFF, 8'h00);
        load(1, 8'h00, 8'hFF, 8'h00, 8'hFF);
        load(2, 8'h12, 8'h34, 8'h56, 8'h80);
        load(3, 8'h00, 8'h00, 8'h00, 8'h7F);
        load(255, 8'hFF, 8'hFF, 8'hFF, 8'h01);
        drain();
        write_reg(cfs_pkg::REG_ENTRY_COUNT, 4);
        write_reg(cfs_pkg::REG_MODE, cfs_pkg::DATA_W'(cfs_pkg::MODE_JUMP));
        repeat (3) tick(0);
        // fade with a period of one and of zero shows the current colour
        drain();
        write_reg(cfs_pkg::REG_MODE, cfs_pkg::DATA_W'(cfs_pkg::MODE_FADE));
        write_reg(cfs_pkg::REG_FADE_PERIOD, 1);
        tick(0);
        tick(1);
        drain();
        write_reg(cfs_pkg::REG_FADE_PERIOD, 0);
        write_reg(cfs_pkg::REG_FIXED_BRIGHT, 8'hFF);
        tick(0);
        // blended fade, then a shorter period caps the progress
        drain();
        write_reg(cfs_pkg::REG_FADE_PERIOD, 4);
        write_reg(cfs_pkg::REG_FIXED_BRIGHT, 0);
        tick(1);
        tick(2);
        drain();
        write_reg(cfs_pkg::REG_FADE_PERIOD, 2);
        tick(1);
        send_word(make_word(cfs_pkg::OP_RESTART, 0, 0, 0, 0, 0, 0));
        tick(0);
        // unused mode acts as jump; lowered count puts the position back to zero
        drain();
        write_reg(cfs_pkg::REG_MODE, cfs_pkg::DATA_W'(MODE_UNUSED));
        write_reg(cfs_pkg::REG_ENTRY_COUNT, 2);
        tick(0);
        // strobe cycle of three: colour, black, black, colour
        drain();
        write_reg(cfs_pkg::REG_MODE, cfs_pkg::DATA_W'(cfs_pkg::MODE_STROBE));
        write_reg(cfs_pkg::REG_STROBE_LENGTH, 3);
        write_reg(cfs_pkg::REG_WHITE_LEVEL, 8'hFF);
        repeat (4) tick(0);

        // random phases, one of them fills the rest of the table
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            random_settings();
            in_steady  = (ph == FILL_PHASE - 1 || ph == FILL_PHASE);
            out_steady = in_steady;
            if (ph == FILL_PHASE)
                for (int i = 0; i < DEPTH; i++)
                    if (!frames.loaded[i]) load(i, $urandom, $urandom, $urandom, $urandom);
            repeat (PHASE_WORDS) send_word(random_word());
        end

        drain();
        if (frames.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit
    initial begin
        #LIMIT_NS;
        $display("FAILURE");
        $finish;
    end

endmodule

/* color_flash_sequencer.f */
rtl/cfs_pkg.sv
rtl/cfs_divider.sv
rtl/cfs_datapath.sv
rtl/cfs_ctrl.sv
rtl/cfs_regs.sv
rtl/color_flash_sequencer.sv
test/tb_top.sv
